>>> src/wsfr_pkg.sv
// ----------------------------------------------------------------------------
// wsfr_pkg
// shared types and constants for the websocket frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package wsfr_pkg;

  // width of the payload length accumulator and counter
  localparam int unsigned LenWidth = 16;

  // extended length selectors in the 7-bit length field
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  // opcodes
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [2:0] ERR_RESERVED  = 3'd0;
  localparam logic [2:0] ERR_TOO_BIG   = 3'd1;
  localparam logic [2:0] ERR_UNSTARTED = 3'd2;
  localparam logic [2:0] ERR_NESTING   = 3'd3;
  localparam logic [2:0] ERR_NONFIN_CT = 3'd4;
  localparam logic [2:0] ERR_BAD_FRAG  = 3'd5;

  // header parse phase
  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  // one result item
  typedef struct packed {
    logic [2:0] error_code;
    logic       is_final;
    logic [3:0] frame_opcode;
    logic [7:0] payload_byte;
    logic [1:0] result_kind;
    logic       last_of_frame;
  } result_t;

  function automatic logic is_control(input logic [3:0] op);
    return (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
  endfunction

endpackage

`default_nettype wire

>>> src/websocket_frame_receiver.sv
// ----------------------------------------------------------------------------
// websocket_frame_receiver
// byte-wide frame deframer: header parse, unmasking, sequencing checks
// ----------------------------------------------------------------------------
// output: a result item is registered into the output register, or into the
//   one-item skid stage while the output register is full and not read
// throughput: one byte per cycle while the skid stage is empty; the
//   header/unmask logic is a single pass into the state and result registers
// reset: rst (synchronous) returns the parser to the first header byte,
//   clears the halt and the open-message flag, and sets max length to 65535
`default_nettype none

module websocket_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: max_frame_len
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  // received byte stream
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // result stream
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [11:8] frame_opcode,
                                           // [12] is_final, [15:13] error_code
  output      logic        m_axis_tlast,   // last_of_frame
  output      logic [1:0]  m_axis_tuser    // [1:0] result_kind
);

  import wsfr_pkg::*;

  // configuration register
  logic [15:0] max_frame_len;

  // parser state
  phase_t              phase,          phase_next;
  logic [3:0]          opcode,         opcode_next;
  logic                final_flag,     final_flag_next;
  logic                masked,         masked_next;
  logic [LenWidth-1:0] length_accum,   length_accum_next;
  logic                len_ovf,        len_ovf_next;
  logic [2:0]          hdr_count,      hdr_count_next;
  logic [31:0]         mask_key,       mask_key_next;
  logic [LenWidth-1:0] payload_count,  payload_count_next;
  logic                in_message,     in_message_next;
  logic                halted,         halted_next;

  // output register and skid stage
  logic    out_valid, skid_valid;
  result_t out_res,   skid_res;

  logic    accept;
  logic    pop;
  logic    res_valid;
  result_t res;

  // working signals of the single pass
  logic [7:0]          b;
  logic                len_done;
  logic                hdr_done;
  logic                err_set;
  logic [2:0]          err_code;
  logic [7:0]          key_byte;
  logic [LenWidth-1:0] count_inc;

  assign b             = s_axis_tdata;
  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = out_valid && m_axis_tready;

  // mask key byte chosen by payload index mod 4, first key byte in the top
  always_comb begin
    case (payload_count[1:0])
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  assign count_inc = payload_count + LenWidth'(1);

  // ---------------------------------------------------------------------------
  // one pass over the accepted byte
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_next         = phase;
    opcode_next        = opcode;
    final_flag_next    = final_flag;
    masked_next        = masked;
    length_accum_next  = length_accum;
    len_ovf_next       = len_ovf;
    hdr_count_next     = hdr_count;
    mask_key_next      = mask_key;
    payload_count_next = payload_count;
    in_message_next    = in_message;
    halted_next        = halted;

    len_done  = 1'b0;
    hdr_done  = 1'b0;
    err_set   = 1'b0;
    err_code  = ERR_RESERVED;
    res_valid = 1'b0;
    res       = '0;

    unique case (phase)
      PH_HDR1: begin
        masked_next  = b[7];
        len_ovf_next = 1'b0;
        if (b[6:0] < LEN7_EXT16) begin
          length_accum_next = LenWidth'(b[6:0]);
          len_done          = 1'b1;
        end else begin
          length_accum_next = '0;
          hdr_count_next    = (b[6:0] == LEN7_EXT64) ? 3'd7 : 3'd1;
          phase_next        = PH_EXTLEN;
        end
      end

      PH_EXTLEN: begin
        // anything shifted out past the accumulator means the frame is too big
        if (length_accum[LenWidth-1 -: 8] != 8'd0) begin
          len_ovf_next = 1'b1;
        end
        length_accum_next = {length_accum[LenWidth-9:0], b};
        if (hdr_count == 3'd0) begin
          len_done = 1'b1;
        end else begin
          hdr_count_next = hdr_count - 3'd1;
        end
      end

      PH_MASK: begin
        mask_key_next = {mask_key[23:0], b};
        if (hdr_count == 3'd0) begin
          hdr_done = 1'b1;
        end else begin
          hdr_count_next = hdr_count - 3'd1;
        end
      end

      PH_PAYLOAD: begin
        payload_count_next = count_inc;
        res_valid          = 1'b1;
        res.result_kind    = KIND_DATA;
        res.payload_byte   = b ^ key_byte;
        if (count_inc >= length_accum) begin
          res.last_of_frame = 1'b1;
          phase_next        = PH_HDR0;
        end
      end

      default: begin
        // first header byte; unused phase codes land here too
        opcode_next       = b[3:0];
        final_flag_next   = b[7];
        mask_key_next     = '0;
        masked_next       = 1'b0;
        length_accum_next = '0;
        len_ovf_next      = 1'b0;
        if (b[6:4] != 3'd0) begin
          err_set  = 1'b1;
          err_code = ERR_RESERVED;
        end else begin
          phase_next = PH_HDR1;
        end
      end
    endcase

    // length complete: limit check, then mask key or end of header
    if (len_done) begin
      if (len_ovf_next || (length_accum_next > LenWidth'(max_frame_len))) begin
        err_set  = 1'b1;
        err_code = ERR_TOO_BIG;
      end else if (masked_next) begin
        hdr_count_next = 3'd3;
        phase_next     = PH_MASK;
      end else begin
        hdr_done = 1'b1;
      end
    end

    // header complete: fragment sequencing
    if (hdr_done) begin
      if (!in_message) begin
        if (opcode_next == OP_CONT) begin
          err_set  = 1'b1;
          err_code = ERR_UNSTARTED;
        end else if (!final_flag_next) begin
          if ((opcode_next == OP_TEXT) || (opcode_next == OP_BINARY)) begin
            in_message_next = 1'b1;
          end else begin
            err_set  = 1'b1;
            err_code = ERR_BAD_FRAG;
          end
        end
      end else begin
        if (opcode_next == OP_CONT) begin
          if (final_flag_next) begin
            in_message_next = 1'b0;
          end
        end else if (final_flag_next) begin
          if (!is_control(opcode_next)) begin
            err_set  = 1'b1;
            err_code = ERR_NESTING;
          end
        end else begin
          err_set  = 1'b1;
          err_code = ERR_NONFIN_CT;
        end
      end

      if (!err_set) begin
        if (length_accum_next == '0) begin
          phase_next        = PH_HDR0;
          res_valid         = 1'b1;
          res.result_kind   = KIND_EMPTY;
          res.last_of_frame = 1'b1;
        end else begin
          payload_count_next = '0;
          phase_next         = PH_PAYLOAD;
        end
      end
    end

    // any error halts the block until reset
    if (err_set) begin
      halted_next       = 1'b1;
      phase_next        = PH_HDR0;
      res_valid         = 1'b1;
      res.result_kind   = KIND_ERROR;
      res.payload_byte  = 8'd0;
      res.last_of_frame = 1'b0;
      res.error_code    = err_code;
    end

    // opcode and final flag of the current frame go with every result
    res.frame_opcode = opcode_next;
    res.is_final     = final_flag_next;

    // a halted block swallows every byte
    if (halted) begin
      res_valid = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // configuration and parser state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len <= 16'hFFFF;
    end else if (cfg_wr_en) begin
      max_frame_len <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HDR0;
      opcode        <= '0;
      final_flag    <= 1'b0;
      masked        <= 1'b0;
      length_accum  <= '0;
      len_ovf       <= 1'b0;
      hdr_count     <= '0;
      mask_key      <= '0;
      payload_count <= '0;
      in_message    <= 1'b0;
      halted        <= 1'b0;
    end else if (accept && !halted) begin
      phase         <= phase_next;
      opcode        <= opcode_next;
      final_flag    <= final_flag_next;
      masked        <= masked_next;
      length_accum  <= length_accum_next;
      len_ovf       <= len_ovf_next;
      hdr_count     <= hdr_count_next;
      mask_key      <= mask_key_next;
      payload_count <= payload_count_next;
      in_message    <= in_message_next;
      halted        <= halted_next;
    end
  end

  // ---------------------------------------------------------------------------
  // output register with skid stage: input stalls only while a second result waits
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // input is held off; drain the skid item into the output register
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (accept && res_valid) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_res <= skid_res;
      end
    end else if (accept && res_valid) begin
      if (!out_valid || pop) begin
        out_res <= res;
      end else begin
        skid_res <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_res.error_code, out_res.is_final,
                          out_res.frame_opcode, out_res.payload_byte};
  assign m_axis_tlast  = out_res.last_of_frame;
  assign m_axis_tuser  = out_res.result_kind;

endmodule

`default_nettype wire
